// ===== rtl/core/ddsp_pkg.sv =====
// Package for the differential drive slew-limited PWM block.
// Holds command, direction and register index codes plus Q.12 constants.
// No dependencies.
`timescale 1ns / 1ps

package ddsp_pkg;

    // Q.12 fixed point: 1.0 is 4096
    localparam int unsigned QW       = 14;    // width of a Q.12 value in [-1.0, 1.0]
    localparam int          Q_ONE    = 4096;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned DUTY_MAX = 255;

    // Register widths
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned SLEW_W   = 14;
    localparam int unsigned DBAND_W  = 13;
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned CFG_DW   = 16;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd20;
    localparam logic [SLEW_W-1:0]   SLEW_RST   = 14'd205;
    localparam logic [DBAND_W-1:0]  DBAND_RST  = 13'd164;

    // Register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_TICK_PERIOD  = 3'd0,
        REG_SLEW_STEP    = 3'd1,
        REG_DEADBAND     = 3'd2,
        REG_INVERT_LEFT  = 3'd3,
        REG_INVERT_RIGHT = 3'd4
    } t_reg_idx;

    // Input commands
    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_STOP    = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_INHIBIT = 2'd3
    } t_cmd;

    // Direction codes
    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

endpackage

// ===== rtl/core/differential_drive_slew_pwm.sv =====
// Top level of the differential drive slew-limited PWM block.
// Input register, single-pass control logic and result register.
// Depends on ddsp_pkg.
`timescale 1ns / 1ps

// Takes one item per clock cycle while the input is not stalled. An accepted item
// is held in the input register; its result, if it has one, passes from there
// into the result register, which drives the output. Set and inhibit items,
// and tick items whose period has not yet run out, give no result and leave the
// input register at once. The input stalls only while a result-bearing item sits
// in the input register and the result register holds an item not yet taken.
module differential_drive_slew_pwm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [ddsp_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [ddsp_pkg::CFG_DW-1:0]    i_cfg_wdata,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_command,
    input  logic signed [15:0]             i_left_request,
    input  logic signed [15:0]             i_right_request,
    input  logic                           i_inhibit_value,
    input  logic [31:0]                    i_now_ms,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ddsp_pkg::DUTY_W-1:0]    o_left_duty,
    output logic [1:0]                     o_left_dir,
    output logic [ddsp_pkg::DUTY_W-1:0]    o_right_duty,
    output logic [1:0]                     o_right_dir,
    output logic signed [ddsp_pkg::QW-1:0] o_commanded_left,
    output logic signed [ddsp_pkg::QW-1:0] o_commanded_right
);

    localparam int unsigned QW = ddsp_pkg::QW;
    localparam int unsigned DW = ddsp_pkg::DUTY_W;
    localparam int unsigned MW = QW - 1;           // magnitude width
    localparam int unsigned PW = MW + DW;          // magnitude times 255

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Clamp a 16-bit request to plus or minus 1.0
    function automatic logic signed [QW-1:0] clamp_unit(input logic signed [15:0] v);
        logic signed [15:0] lim;
        lim = 16'(ddsp_pkg::Q_ONE);
        if (v > lim) begin
            return QW'(ddsp_pkg::Q_ONE);
        end else if (v < -lim) begin
            return QW'(-ddsp_pkg::Q_ONE);
        end else begin
            return v[QW-1:0];
        end
    endfunction

    // Move applied toward target by at most step
    function automatic logic signed [QW-1:0] slew_toward(
        input logic signed [QW-1:0]          applied,
        input logic signed [QW-1:0]          target,
        input logic [ddsp_pkg::SLEW_W-1:0]   step
    );
        logic signed [QW:0]   d;
        logic signed [QW+1:0] d_ext;
        logic signed [QW+1:0] s_ext;
        logic signed [QW:0]   sum;
        d     = {target[QW-1], target} - {applied[QW-1], applied};
        d_ext = {d[QW], d};
        s_ext = {2'b00, step};
        if (d_ext > s_ext) begin
            d_ext = s_ext;
        end else if (d_ext < -s_ext) begin
            d_ext = -s_ext;
        end
        sum = {applied[QW-1], applied} + d_ext[QW:0];
        return sum[QW-1:0];
    endfunction

    // Result fields for one side
    typedef struct packed {
        logic [DW-1:0]  duty;
        ddsp_pkg::t_dir dir;
    } t_side;

    function automatic t_side drive_side(
        input logic signed [QW-1:0]         v_in,
        input logic                         inv,
        input logic [ddsp_pkg::DBAND_W-1:0] dband
    );
        logic signed [QW-1:0] v;
        logic [QW-1:0]        neg;
        logic [MW-1:0]        mag;
        logic [PW-1:0]        prod;
        logic [PW-13:0]       pwm;
        t_side                r;
        v    = inv ? -v_in : v_in;
        neg  = -v;
        mag  = v[QW-1] ? neg[MW-1:0] : v[MW-1:0];
        if (mag < dband) begin
            v   = '0;
            mag = '0;
        end
        // times 255 as times 256 minus one
        prod = {mag, {DW{1'b0}}} - {{DW{1'b0}}, mag};
        pwm  = prod[PW-1:12];
        if (pwm > (PW-12)'(ddsp_pkg::DUTY_MAX)) begin
            r.duty = DW'(ddsp_pkg::DUTY_MAX);
        end else begin
            r.duty = pwm[DW-1:0];
        end
        if (v == '0) begin
            r.dir = ddsp_pkg::DIR_STOP;
        end else if (v[QW-1]) begin
            r.dir = ddsp_pkg::DIR_REV;
        end else begin
            r.dir = ddsp_pkg::DIR_FWD;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ddsp_pkg::PERIOD_W-1:0] r_period;
    logic [ddsp_pkg::SLEW_W-1:0]   r_slew;
    logic [ddsp_pkg::DBAND_W-1:0]  r_dband;
    logic                          r_inv_left;
    logic                          r_inv_right;

    // Latch register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= ddsp_pkg::PERIOD_RST;
            r_slew      <= ddsp_pkg::SLEW_RST;
            r_dband     <= ddsp_pkg::DBAND_RST;
            r_inv_left  <= 1'b0;
            r_inv_right <= 1'b0;
        end else if (i_cfg_we) begin
            case (ddsp_pkg::t_reg_idx'(i_cfg_addr))
                ddsp_pkg::REG_TICK_PERIOD:  r_period    <= i_cfg_wdata[ddsp_pkg::PERIOD_W-1:0];
                ddsp_pkg::REG_SLEW_STEP:    r_slew      <= i_cfg_wdata[ddsp_pkg::SLEW_W-1:0];
                ddsp_pkg::REG_DEADBAND:     r_dband     <= i_cfg_wdata[ddsp_pkg::DBAND_W-1:0];
                ddsp_pkg::REG_INVERT_LEFT:  r_inv_left  <= i_cfg_wdata[0];
                ddsp_pkg::REG_INVERT_RIGHT: r_inv_right <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                  r_in_valid;
    ddsp_pkg::t_cmd        r_cmd;
    logic signed [15:0]    r_left_req;
    logic signed [15:0]    r_right_req;
    logic                  r_inh_val;
    logic [31:0]           r_now;

    logic s1_fire;      // item leaves the input register
    logic s1_result;    // that item gives a result
    logic out_load;     // result register can take a new item
    logic in_accept;

    assign out_load   = !o_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && s1_result && !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign s1_fire    = r_in_valid && (!s1_result || out_load);

    // Advance the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (s1_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the payload of the waiting item
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd       <= ddsp_pkg::t_cmd'(i_command);
            r_left_req  <= i_left_request;
            r_right_req <= i_right_request;
            r_inh_val   <= i_inhibit_value;
            r_now       <= i_now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Drive state and control logic
    // ------------------------------------------------------------------
    logic signed [QW-1:0] r_left_target, r_right_target;
    logic signed [QW-1:0] r_left_applied, r_right_applied;
    logic                 r_fwd_blocked;
    logic [31:0]          r_last_update;

    logic signed [QW-1:0] n_left_target, n_right_target;
    logic signed [QW-1:0] n_left_applied, n_right_applied;
    logic                 n_fwd_blocked;
    logic [31:0]          n_last_update;
    logic [31:0]          elapsed;
    logic                 tick_due;
    logic signed [QW-1:0] tgt_left, tgt_right;
    t_side                side_left, side_right;

    assign elapsed  = r_now - r_last_update;
    assign tick_due = elapsed >= {{(32-ddsp_pkg::PERIOD_W){1'b0}}, r_period};

    // Work out the next state for the waiting item
    always_comb begin
        n_left_target   = r_left_target;
        n_right_target  = r_right_target;
        n_left_applied  = r_left_applied;
        n_right_applied = r_right_applied;
        n_fwd_blocked   = r_fwd_blocked;
        n_last_update   = r_last_update;
        s1_result       = 1'b0;
        tgt_left        = r_left_target;
        tgt_right       = r_right_target;
        if (r_fwd_blocked) begin
            if (!r_left_target[QW-1])  tgt_left  = '0;
            if (!r_right_target[QW-1]) tgt_right = '0;
        end
        case (r_cmd)
            ddsp_pkg::CMD_SET: begin
                n_left_target  = clamp_unit(r_left_req);
                n_right_target = clamp_unit(r_right_req);
            end
            ddsp_pkg::CMD_STOP: begin
                n_left_target   = '0;
                n_right_target  = '0;
                n_left_applied  = '0;
                n_right_applied = '0;
                s1_result       = 1'b1;
            end
            ddsp_pkg::CMD_INHIBIT: begin
                n_fwd_blocked = r_inh_val;
            end
            ddsp_pkg::CMD_TICK: begin
                if (tick_due) begin
                    n_last_update   = r_now;
                    n_left_applied  = slew_toward(r_left_applied, tgt_left, r_slew);
                    n_right_applied = slew_toward(r_right_applied, tgt_right, r_slew);
                    s1_result       = 1'b1;
                end
            end
            default: ;
        endcase
        side_left  = drive_side(n_left_applied, r_inv_left, r_dband);
        side_right = drive_side(n_right_applied, r_inv_right, r_dband);
    end

    // Commit drive state as the item leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_target   <= '0;
            r_right_target  <= '0;
            r_left_applied  <= '0;
            r_right_applied <= '0;
            r_fwd_blocked   <= 1'b0;
            r_last_update   <= '0;
        end else if (s1_fire) begin
            r_left_target   <= n_left_target;
            r_right_target  <= n_right_target;
            r_left_applied  <= n_left_applied;
            r_right_applied <= n_right_applied;
            r_fwd_blocked   <= n_fwd_blocked;
            r_last_update   <= n_last_update;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                 r_out_valid;
    logic [DW-1:0]        r_left_duty, r_right_duty;
    ddsp_pkg::t_dir       r_left_dir, r_right_dir;
    logic signed [QW-1:0] r_cmd_left, r_cmd_right;

    // Track result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= s1_fire && s1_result;
        end
    end

    // Load the result fields
    always_ff @(posedge i_clk) begin
        if (out_load && s1_fire && s1_result) begin
            r_left_duty  <= side_left.duty;
            r_left_dir   <= side_left.dir;
            r_right_duty <= side_right.duty;
            r_right_dir  <= side_right.dir;
            r_cmd_left   <= n_left_target;
            r_cmd_right  <= n_right_target;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_left_duty       = r_left_duty;
    assign o_left_dir        = r_left_dir;
    assign o_right_duty      = r_right_duty;
    assign o_right_dir       = r_right_dir;
    assign o_commanded_left  = r_cmd_left;
    assign o_commanded_right = r_cmd_right;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A stop item yields an all-zero result
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_cmd == ddsp_pkg::CMD_STOP) |=>
            (o_out_valid && o_left_duty == '0 && o_right_duty == '0 &&
             o_left_dir == ddsp_pkg::DIR_STOP && o_right_dir == ddsp_pkg::DIR_STOP &&
             o_commanded_left == '0 && o_commanded_right == '0))
        else $error("stop result not zero");

    // Applied values never leave plus or minus 1.0
    a_applied_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left_applied <= QW'(ddsp_pkg::Q_ONE) && r_left_applied >= QW'(-ddsp_pkg::Q_ONE) &&
         r_right_applied <= QW'(ddsp_pkg::Q_ONE) &&
         r_right_applied >= QW'(-ddsp_pkg::Q_ONE)))
        else $error("applied value out of range");

    // A result-bearing item never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !(s1_fire && s1_result))
        else $error("result register overwritten while stalled");

    // A tick that is not due changes no drive state
    a_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_cmd == ddsp_pkg::CMD_TICK && !tick_due) |=>
            ($stable(r_left_applied) && $stable(r_right_applied) && $stable(r_last_update)))
        else $error("idle tick changed state");

    // Direction codes stay within stop, forward and reverse
    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_dir != 2'd3 && o_right_dir != 2'd3))
        else $error("invalid direction code");

endmodule
